// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Plain invariant sampled on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant failed");

`endif

// ----- rtl/dttf_pkg.sv -----
`default_nettype none
package dttf_pkg;

   // Default widths for the top level.
   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH_DEF     = 16;

   // CORDIC datapath: components sit at bit 61 - component width, so the
   // signed working width is the same for every component width.
   localparam int DATA_WIDTH   = 63;
   localparam int ACC_WIDTH    = 32;
   localparam int ITERATIONS   = 32;
   localparam int QUARTER_BIT  = ACC_WIDTH - 2;

   // Prerotate register, 32 rotation stages, output register; the two
   // terms beyond ITERATIONS are the prerotate and output registers.
   localparam int PIPE_LATENCY = ITERATIONS + 2;

   // Register indexes on the csr port.
   typedef enum logic [0:0] {
      CSR_BYPASS          = 1'b0,
      CSR_NEAR_ZERO_LIMIT = 1'b1
   } csr_index_type;

   // Word carried down the rotation pipeline.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] x;
      logic signed [DATA_WIDTH-1:0] y;
      logic [ACC_WIDTH-1:0]         acc;
      logic                         done;
      logic                         force_zero;
   } dttf_stage_type;

   // atan(2^-i) as a fraction of a turn, scaled by 2^32, rounded.
   function automatic logic [ACC_WIDTH-1:0] atan_turn(input int idx);
      logic [ACC_WIDTH-1:0] val;
      unique case (idx)
         0:  val = 32'h20000000;
         1:  val = 32'h12E4051E;
         2:  val = 32'h09FB385B;
         3:  val = 32'h051111D4;
         4:  val = 32'h028B0D43;
         5:  val = 32'h0145D7E1;
         6:  val = 32'h00A2F61E;
         7:  val = 32'h00517C55;
         8:  val = 32'h0028BE53;
         9:  val = 32'h00145F2F;
         10: val = 32'h000A2F98;
         11: val = 32'h000517CC;
         12: val = 32'h00028BE6;
         13: val = 32'h000145F3;
         14: val = 32'h0000A2FA;
         15: val = 32'h0000517D;
         16: val = 32'h000028BE;
         17: val = 32'h0000145F;
         18: val = 32'h00000A30;
         19: val = 32'h00000518;
         20: val = 32'h0000028C;
         21: val = 32'h00000146;
         22: val = 32'h000000A3;
         23: val = 32'h00000051;
         24: val = 32'h00000029;
         25: val = 32'h00000014;
         26: val = 32'h0000000A;
         27: val = 32'h00000005;
         28: val = 32'h00000003;
         29: val = 32'h00000001;
         30: val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/dttf_prerotate.sv -----
`default_nettype none
module dttf_prerotate
   import dttf_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept_i,
   input  wire logic signed [COMPONENT_WIDTH-1:0] dir_x_i,
   input  wire logic signed [COMPONENT_WIDTH-1:0] dir_y_i,
   input  wire logic                              bypass_i,
   input  wire logic [COMPONENT_WIDTH-2:0]        near_zero_limit_i,
   output logic                                   valid_o,
   output dttf_stage_type                         data_o
);

   localparam int GUARD_SHIFT = DATA_WIDTH - 2 - COMPONENT_WIDTH;

   logic signed [COMPONENT_WIDTH:0] x_ext, y_ext, rot_x, rot_y;
   logic [COMPONENT_WIDTH:0]        abs_x, abs_y, lim_ext;
   logic [1:0]                      quarters;
   logic                            x_pos, y_pos, x_neg, y_neg;
   logic                            valid_ff, valid_in;
   dttf_stage_type                  data_ff, data_in;

   // One extra bit so the most negative component negates cleanly.
   assign x_ext   = (COMPONENT_WIDTH + 1)'(dir_x_i);
   assign y_ext   = (COMPONENT_WIDTH + 1)'(dir_y_i);
   assign lim_ext = (COMPONENT_WIDTH + 1)'(near_zero_limit_i);
   assign abs_x   = x_ext[COMPONENT_WIDTH] ? (COMPONENT_WIDTH + 1)'(-x_ext) : x_ext;
   assign abs_y   = y_ext[COMPONENT_WIDTH] ? (COMPONENT_WIDTH + 1)'(-y_ext) : y_ext;

   assign x_neg = x_ext[COMPONENT_WIDTH];
   assign y_neg = y_ext[COMPONENT_WIDTH];
   assign x_pos = !x_neg && (x_ext != '0);
   assign y_pos = !y_neg && (y_ext != '0);

   // Whole quarter turns until x > 0 and y >= 0.
   always_comb begin
      priority if (x_pos && !y_neg) begin
         rot_x    = x_ext;
         rot_y    = y_ext;
         quarters = 2'd0;
      end else if (!x_pos && y_pos) begin
         rot_x    = y_ext;
         rot_y    = -x_ext;
         quarters = 2'd1;
      end else if (x_neg && !y_pos) begin
         rot_x    = -x_ext;
         rot_y    = -y_ext;
         quarters = 2'd2;
      end else begin
         rot_x    = -y_ext;
         rot_y    = x_ext;
         quarters = 2'd3;
      end
   end

   // Scale into the working width and flag forced-zero words.
   always_comb begin
      valid_in           = accept_i;
      data_in.x          = DATA_WIDTH'(rot_x) <<< GUARD_SHIFT;
      data_in.y          = DATA_WIDTH'(rot_y) <<< GUARD_SHIFT;
      data_in.acc        = ACC_WIDTH'(quarters) << QUARTER_BIT;
      data_in.done       = 1'b0;
      data_in.force_zero = bypass_i || ((abs_x <= lim_ext) && (abs_y <= lim_ext));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule
`default_nettype wire

// ----- rtl/dttf_cordic_stage.sv -----
`default_nettype none
module dttf_cordic_stage
   import dttf_pkg::*;
#(
   parameter int STAGE_INDEX = 0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           valid_i,
   input  dttf_stage_type      data_i,
   output logic                valid_o,
   output dttf_stage_type      data_o
);

   localparam logic [ACC_WIDTH-1:0] ANGLE_STEP = atan_turn(STAGE_INDEX);

   logic signed [DATA_WIDTH-1:0] x_cur, y_cur, dx, dy;
   logic                         y_zero;
   logic                         valid_ff, valid_in;
   dttf_stage_type               data_ff, data_in;

   assign x_cur  = data_i.x;
   assign y_cur  = data_i.y;
   assign dx     = x_cur >>> STAGE_INDEX;
   assign dy     = y_cur >>> STAGE_INDEX;
   assign y_zero = (y_cur == '0);

   // One micro-rotation; a word whose y reached zero passes unchanged.
   always_comb begin
      data_in = data_i;
      if (data_i.done || y_zero) begin
         data_in.done = 1'b1;
      end else if (!y_cur[DATA_WIDTH-1]) begin
         data_in.x   = x_cur + dy;
         data_in.y   = y_cur - dx;
         data_in.acc = data_i.acc + ANGLE_STEP;
      end else begin
         data_in.x   = x_cur - dy;
         data_in.y   = y_cur + dx;
         data_in.acc = data_i.acc - ANGLE_STEP;
      end
      valid_in = valid_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule
`default_nettype wire

// ----- rtl/direction_to_turn_fraction.sv -----
`default_nettype none
// Channel   Ports                                 Handshake
// request   req_dir_x, req_dir_y                  start high, busy low
// response  rsp_weight                            rsp_valid strobe, one cycle
// csr       csr_index, csr_wdata                  csr_write_enable, no wait
//
// One word enters per cycle while busy is low; each result passes through
// one prerotate register, one register per CORDIC micro-rotation (32) and
// one output register.
// Synchronous reset clears the valid bits and loads the csr defaults;
// busy is high only during reset. The receiver cannot stall, so nothing
// in the pipeline ever waits.
module direction_to_turn_fraction
   import dttf_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_dir_x,
   input  wire logic signed [COMPONENT_WIDTH-1:0] req_dir_y,
   output logic                                   rsp_valid,
   output logic [ANGLE_WIDTH-1:0]                 rsp_weight,
   input  wire logic                              csr_write_enable,
   input  wire logic [0:0]                        csr_index,
   input  wire logic [COMPONENT_WIDTH-2:0]        csr_wdata
);

   logic                         bypass_ff, bypass_in;
   logic [COMPONENT_WIDTH-2:0]   near_zero_limit_ff, near_zero_limit_in;
   logic                         accept;
   logic                         stage_valid [0:ITERATIONS];
   dttf_stage_type               stage_data  [0:ITERATIONS];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_WIDTH-1:0]       rsp_weight_ff, rsp_weight_in;

   assign busy   = reset;
   assign accept = start && !busy;

   // Configuration registers.
   always_comb begin
      bypass_in          = bypass_ff;
      near_zero_limit_in = near_zero_limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BYPASS:          bypass_in          = csr_wdata[0];
            CSR_NEAR_ZERO_LIMIT: near_zero_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff          <= 1'b0;
         near_zero_limit_ff <= (COMPONENT_WIDTH - 1)'(1);
      end else begin
         bypass_ff          <= bypass_in;
         near_zero_limit_ff <= near_zero_limit_in;
      end
   end

   dttf_prerotate #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_prerotate (
      .clock             (clock),
      .reset             (reset),
      .accept_i          (accept),
      .dir_x_i           (req_dir_x),
      .dir_y_i           (req_dir_y),
      .bypass_i          (bypass_ff),
      .near_zero_limit_i (near_zero_limit_ff),
      .valid_o           (stage_valid[0]),
      .data_o            (stage_data[0])
   );

   // Micro-rotation chain.
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      dttf_cordic_stage #(
         .STAGE_INDEX (i)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .valid_i (stage_valid[i]),
         .data_i  (stage_data[i]),
         .valid_o (stage_valid[i+1]),
         .data_o  (stage_data[i+1])
      );
   end

   // Output register: truncate the turn fraction, zero when forced.
   always_comb begin
      rsp_valid_in  = stage_valid[ITERATIONS];
      rsp_weight_in = stage_data[ITERATIONS].force_zero ? '0 :
                      stage_data[ITERATIONS].acc[ACC_WIDTH-1 -: ANGLE_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_weight_ff <= rsp_weight_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_weight = rsp_weight_ff;

endmodule
`default_nettype wire

// ----- rtl/dttf_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module dttf_checker
   import dttf_pkg::*;
#(
   parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
   parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic signed [COMPONENT_WIDTH-1:0] req_dir_x,
   input wire logic signed [COMPONENT_WIDTH-1:0] req_dir_y,
   input wire logic                              rsp_valid,
   input wire logic [ANGLE_WIDTH-1:0]            rsp_weight,
   input wire logic                              csr_write_enable,
   input wire logic [0:0]                        csr_index,
   input wire logic [COMPONENT_WIDTH-2:0]        csr_wdata
);

   logic accept;
   logic bypass_ff, bypass_in;

   assign accept = start && !busy;

   // Shadow of the bypass register as seen on the csr port.
   always_comb begin
      bypass_in = bypass_ff;
      if (csr_write_enable && (csr_index == CSR_BYPASS)) begin
         bypass_in = csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else begin
         bypass_ff <= bypass_in;
      end
   end

   // Every accepted word gives exactly one strobe at fixed latency.
   `ASSERT_PROP(a_word_gives_result, clock, reset, accept |-> ##PIPE_LATENCY rsp_valid)
   `ASSERT_PROP(a_no_spurious_result, clock, reset, !accept |-> ##PIPE_LATENCY !rsp_valid)
   // Bypass and the zero vector both come out as zero.
   `ASSERT_PROP(a_bypass_zero, clock, reset, (accept && bypass_ff) |-> ##PIPE_LATENCY (rsp_weight == '0))
   `ASSERT_PROP(a_null_vector_zero, clock, reset, (accept && (req_dir_x == '0) && (req_dir_y == '0)) |-> ##PIPE_LATENCY (rsp_weight == '0))

endmodule

bind direction_to_turn_fraction dttf_checker #(
   .COMPONENT_WIDTH (COMPONENT_WIDTH),
   .ANGLE_WIDTH     (ANGLE_WIDTH)
) u_dttf_checker (.*);
`default_nettype wire
